>>> hw/rtl/gdbd_pkg.sv
// Shared types, constants and helper functions for the packet deframer.
// Used by every module under hw/rtl; depends on nothing else.
package gdbd_pkg;

  localparam int BUFFER_BYTES_DEFAULT = 1024;
  localparam int QUEUE_DEPTH          = 2;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_BRACE   = 8'h7d;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_EOT     = 8'h04;
  localparam logic [7:0] ESC_XOR    = 8'h20;

  localparam logic [7:0] RESET_REMOTE_START = 8'h21;
  localparam logic [7:0] RESET_REMOTE_END   = 8'h23;

  localparam logic [1:0] CFG_NO_ACK_MODE  = 2'd0;
  localparam logic [1:0] CFG_REMOTE_START = 2'd1;
  localparam logic [1:0] CFG_REMOTE_END   = 2'd2;

  typedef enum logic [2:0] {
    EV_GDB_BYTE,
    EV_REMOTE_BYTE,
    EV_ACCEPT,
    EV_REJECT,
    EV_REMOTE_DONE,
    EV_EOT,
    EV_ABORT
  } event_kind_t;

  typedef enum logic [1:0] {
    ACK_NONE,
    ACK_PLUS,
    ACK_MINUS
  } ack_reply_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [7:0]  byte_value;
    logic [9:0]  byte_index;
    logic [10:0] packet_length;
    logic        is_notification;
    ack_reply_t  ack_reply;
  } out_item_t;

  // Classified item handed from the front part to the packet engine.
  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
    logic       is_dollar;
    logic       is_percent;
    logic       is_hash;
    logic       is_brace;
    logic       is_eot;
    logic       is_rstart;
    logic       is_rend;
    logic       rsv_plain;
    logic       rsv_escaped;
    logic [3:0] nibble;
  } class_t;

  function automatic logic is_reserved(input logic [7:0] b);
    return (b == CH_DOLLAR) || (b == CH_HASH) || (b == CH_BRACE) || (b == CH_STAR);
  endfunction

  // Characters that are not hex digits count as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h61 + 8'd10);
    return v;
  endfunction

endpackage

>>> hw/rtl/gdbd_classify.sv
// Front part: accepts received bytes and tags them with the character
// classes the packet engine branches on. Depends on gdbd_pkg.
module gdbd_classify (
  input  gdbd_pkg::in_item_t item,
  input  logic [7:0]         remote_start_byte,
  input  logic [7:0]         remote_end_byte,
  output gdbd_pkg::class_t   cls
);

  always_comb begin
    cls.mode        = item.mode;
    cls.rx_byte     = item.rx_byte;
    cls.is_dollar   = (item.rx_byte == gdbd_pkg::CH_DOLLAR);
    cls.is_percent  = (item.rx_byte == gdbd_pkg::CH_PERCENT);
    cls.is_hash     = (item.rx_byte == gdbd_pkg::CH_HASH);
    cls.is_brace    = (item.rx_byte == gdbd_pkg::CH_BRACE);
    cls.is_eot      = (item.rx_byte == gdbd_pkg::CH_EOT);
    cls.is_rstart   = (item.rx_byte == remote_start_byte);
    cls.is_rend     = (item.rx_byte == remote_end_byte);
    cls.rsv_plain   = gdbd_pkg::is_reserved(item.rx_byte);
    cls.rsv_escaped = gdbd_pkg::is_reserved(item.rx_byte ^ gdbd_pkg::ESC_XOR);
    cls.nibble      = gdbd_pkg::hex_value(item.rx_byte);
  end

endmodule

>>> hw/rtl/gdbd_queue.sv
// Short queue of classified items between the front part and the engine.
// Depends on gdbd_pkg.
module gdbd_queue #(
  parameter int DEPTH = gdbd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gdbd_pkg::class_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output gdbd_pkg::class_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gdbd_pkg::class_t store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_data;
  end

endmodule

>>> hw/rtl/gdbd_engine.sv
// Back part: packet state machine, running checksum and the output register.
// Depends on gdbd_pkg.
module gdbd_engine #(
  parameter int BUFFER_BYTES = gdbd_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                no_ack_mode,
  input  logic                head_valid,
  input  gdbd_pkg::class_t    head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output gdbd_pkg::out_item_t out_data
);

  localparam int CW = $clog2(BUFFER_BYTES + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CAPTURE,
    PH_ESCAPE,
    PH_SUM_HI,
    PH_SUM_LO,
    PH_REMOTE
  } phase_t;

  phase_t        phase, phase_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [7:0]    running_sum, running_sum_next;
  logic [7:0]    received_sum, received_sum_next;
  logic          notify_flag, notify_flag_next;

  logic                res_valid;
  gdbd_pkg::out_item_t res;

  assign pop = head_valid && (!out_valid || !out_stall);

  always_comb begin
    logic [7:0] store_byte;
    logic       store_rsv;
    logic       has_room;
    logic [7:0] full_sum;

    phase_next        = phase;
    byte_count_next   = byte_count;
    running_sum_next  = running_sum;
    received_sum_next = received_sum;
    notify_flag_next  = notify_flag;
    res_valid         = 1'b0;
    res               = '0;

    // Escaped bytes are stored with bit 5 flipped.
    store_byte = (phase == PH_ESCAPE) ? (head.rx_byte ^ gdbd_pkg::ESC_XOR) : head.rx_byte;
    store_rsv  = (phase == PH_ESCAPE) ? head.rsv_escaped : head.rsv_plain;
    has_room   = (byte_count < CW'(BUFFER_BYTES));
    full_sum   = received_sum | {4'd0, head.nibble};

    if (head.mode) begin
      phase_next        = PH_IDLE;
      byte_count_next   = '0;
      running_sum_next  = '0;
      received_sum_next = '0;
      notify_flag_next  = 1'b0;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (head.is_dollar || head.is_percent) begin
            phase_next       = PH_CAPTURE;
            byte_count_next  = '0;
            running_sum_next = '0;
            notify_flag_next = !head.is_dollar;
          end else if (head.is_rstart) begin
            phase_next      = PH_REMOTE;
            byte_count_next = CW'(1);
            res_valid       = 1'b1;
            res.event_kind  = gdbd_pkg::EV_REMOTE_BYTE;
            res.byte_value  = head.rx_byte;
          end else if (head.is_eot) begin
            res_valid         = 1'b1;
            res.event_kind    = gdbd_pkg::EV_EOT;
            res.packet_length = 11'd1;
          end
        end
        PH_CAPTURE, PH_ESCAPE: begin
          if (phase == PH_CAPTURE && head.is_dollar) begin
            byte_count_next       = '0;
            running_sum_next      = '0;
            res_valid             = 1'b1;
            res.event_kind        = gdbd_pkg::EV_ABORT;
            res.packet_length     = 11'(byte_count);
            res.is_notification   = notify_flag;
          end else if (phase == PH_CAPTURE && head.is_hash) begin
            phase_next = PH_SUM_HI;
          end else if (phase == PH_CAPTURE && head.is_brace) begin
            phase_next = PH_ESCAPE;
          end else if (has_room) begin
            // A reserved byte counts in the sum as escape plus the byte xor 0x20.
            phase_next          = PH_CAPTURE;
            running_sum_next    = store_rsv ?
                                  running_sum + gdbd_pkg::CH_BRACE +
                                  (store_byte ^ gdbd_pkg::ESC_XOR) :
                                  running_sum + store_byte;
            byte_count_next     = byte_count + 1'b1;
            res_valid           = 1'b1;
            res.event_kind      = gdbd_pkg::EV_GDB_BYTE;
            res.byte_value      = store_byte;
            res.byte_index      = 10'(byte_count);
            res.is_notification = notify_flag;
          end else if (phase == PH_ESCAPE) begin
            // An escaped byte that does not fit is dropped silently.
            phase_next = PH_CAPTURE;
          end else begin
            phase_next          = PH_IDLE;
            byte_count_next     = '0;
            res_valid           = 1'b1;
            res.event_kind      = gdbd_pkg::EV_ABORT;
            res.packet_length   = 11'(byte_count);
            res.is_notification = notify_flag;
          end
        end
        PH_SUM_HI: begin
          if (!no_ack_mode) received_sum_next = {head.nibble, 4'd0};
          phase_next = PH_SUM_LO;
        end
        PH_SUM_LO: begin
          res_valid           = 1'b1;
          res.event_kind      = gdbd_pkg::EV_ACCEPT;
          res.ack_reply       = gdbd_pkg::ACK_NONE;
          res.packet_length   = 11'(byte_count);
          res.is_notification = notify_flag;
          if (!no_ack_mode) begin
            received_sum_next = full_sum;
            if (full_sum == running_sum) begin
              res.ack_reply = gdbd_pkg::ACK_PLUS;
            end else begin
              res.event_kind = gdbd_pkg::EV_REJECT;
              res.ack_reply  = gdbd_pkg::ACK_MINUS;
            end
          end
          phase_next       = PH_IDLE;
          byte_count_next  = '0;
          notify_flag_next = 1'b0;
        end
        PH_REMOTE: begin
          res_valid         = 1'b1;
          res.packet_length = 11'(byte_count);
          if (head.is_rend) begin
            phase_next      = PH_IDLE;
            byte_count_next = '0;
            res.event_kind  = gdbd_pkg::EV_REMOTE_DONE;
          end else if (head.is_dollar) begin
            phase_next       = PH_CAPTURE;
            byte_count_next  = '0;
            running_sum_next = '0;
            notify_flag_next = 1'b0;
            res.event_kind   = gdbd_pkg::EV_ABORT;
          end else if (has_room) begin
            byte_count_next   = byte_count + 1'b1;
            res.event_kind    = gdbd_pkg::EV_REMOTE_BYTE;
            res.byte_value    = head.rx_byte;
            res.byte_index    = 10'(byte_count);
            res.packet_length = '0;
          end else begin
            phase_next      = PH_IDLE;
            byte_count_next = '0;
            res.event_kind  = gdbd_pkg::EV_ABORT;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_count   <= '0;
      running_sum  <= '0;
      received_sum <= '0;
      notify_flag  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        phase        <= phase_next;
        byte_count   <= byte_count_next;
        running_sum  <= running_sum_next;
        received_sum <= received_sum_next;
        notify_flag  <= notify_flag_next;
        out_valid    <= res_valid;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) out_data <= res;
  end

endmodule

>>> hw/rtl/gdb_rsp_packet_deframer.sv
// Top level of the remote serial protocol packet deframer.
// Depends on gdbd_pkg, gdbd_classify, gdbd_queue and gdbd_engine.
//
// Takes one received byte per item and reports data bytes, packet
// completion with checksum verdict and ack reply, side-channel remote
// packets, end of transmission and aborts, at most one result per item.
// The block sustains one item per clock cycle unless the result side
// stalls: the packet engine updates its state and the running checksum
// for one item each cycle. A two-entry queue ahead of the engine's
// output register lets the input side keep accepting while a result
// waits to be taken. The user must write configuration on the cfg port
// only while no packet is in flight; the block does not enforce this.
module gdb_rsp_packet_deframer #(
  parameter int BUFFER_BYTES = gdbd_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  gdbd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gdbd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  logic       no_ack_mode;
  logic [7:0] remote_start_byte;
  logic [7:0] remote_end_byte;

  gdbd_pkg::class_t cls;
  gdbd_pkg::class_t head;
  logic             full;
  logic             push;
  logic             pop;
  logic             head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      no_ack_mode       <= 1'b0;
      remote_start_byte <= gdbd_pkg::RESET_REMOTE_START;
      remote_end_byte   <= gdbd_pkg::RESET_REMOTE_END;
    end else if (cfg_we) begin
      case (cfg_index)
        gdbd_pkg::CFG_NO_ACK_MODE:  no_ack_mode       <= cfg_data[0];
        gdbd_pkg::CFG_REMOTE_START: remote_start_byte <= cfg_data;
        gdbd_pkg::CFG_REMOTE_END:   remote_end_byte   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign push     = in_valid && !full;

  gdbd_classify u_classify (
    .item              (in_data),
    .remote_start_byte (remote_start_byte),
    .remote_end_byte   (remote_end_byte),
    .cls               (cls)
  );

  gdbd_queue #(
    .DEPTH (gdbd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (cls),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  gdbd_engine #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .no_ack_mode (no_ack_mode),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

>>> tb/rsp_event_checker.sv
`timescale 1ns / 1ps
// Event checker for the packet deframer: watches the input, output and config ports,
// predicts each result and compares it with what the block delivers.
// Depends on gdbd_pkg.
module rsp_event_checker #(
  parameter int BUFFER_BYTES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  gdbd_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  gdbd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output int                  failures,
  output int                  pending
);
  import gdbd_pkg::*;

  typedef enum logic [2:0] {
    RX_IDLE,
    RX_CAPTURE,
    RX_ESCAPE,
    RX_SUM_HI,
    RX_SUM_LO,
    RX_REMOTE
  } rx_phase_t;

  logic        no_ack;
  logic [7:0]  rx_start;
  logic [7:0]  rx_end;

  rx_phase_t   rx_phase;
  int unsigned stored;
  logic [7:0]  sum_run;
  logic [7:0]  sum_rcvd;
  logic        notify;

  out_item_t   expected_events[$];
  int          error_count = 0;

  // Reserved characters count as the escape byte plus their escaped form.
  function automatic logic [7:0] sum_part(input logic [7:0] b);
    case (b)
      CH_DOLLAR, CH_HASH, CH_BRACE, CH_STAR: return CH_BRACE + (b ^ ESC_XOR);
      default: return b;
    endcase
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return c[3:0];
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  function automatic out_item_t event_of(input event_kind_t k, input logic [7:0] v,
                                         input int unsigned idx, input int unsigned len,
                                         input logic nf, input ack_reply_t a);
    out_item_t r;
    r.event_kind      = k;
    r.byte_value      = v;
    r.byte_index      = idx[9:0];
    r.packet_length   = len[10:0];
    r.is_notification = nf;
    r.ack_reply       = a;
    return r;
  endfunction

  function automatic void begin_packet(input logic nf);
    rx_phase = RX_CAPTURE;
    stored   = 0;
    sum_run  = '0;
    notify   = nf;
  endfunction

  function automatic out_item_t store_gdb_byte(input logic [7:0] b);
    out_item_t r;
    r = event_of(EV_GDB_BYTE, b, stored, 0, notify, ACK_NONE);
    sum_run = sum_run + sum_part(b);
    stored++;
    return r;
  endfunction

  function automatic void clear_state();
    rx_phase = RX_IDLE;
    stored   = 0;
    sum_run  = '0;
    sum_rcvd = '0;
    notify   = 1'b0;
  endfunction

  // Advances the predicted state by one item; returns 1 when the item yields a result.
  function automatic bit predict_event(input in_item_t it, output out_item_t r);
    logic [7:0]  c;
    int unsigned n;
    event_kind_t k;
    ack_reply_t  a;
    c = it.rx_byte;
    r = '0;
    if (it.mode) begin
      clear_state();
      return 1'b0;
    end
    case (rx_phase)
      RX_IDLE: begin
        if (c == CH_DOLLAR) begin
          begin_packet(1'b0);
          return 1'b0;
        end
        if (c == CH_PERCENT) begin
          begin_packet(1'b1);
          return 1'b0;
        end
        if (c == rx_start) begin
          rx_phase = RX_REMOTE;
          stored = 1;
          r = event_of(EV_REMOTE_BYTE, c, 0, 0, 1'b0, ACK_NONE);
          return 1'b1;
        end
        if (c == CH_EOT) begin
          r = event_of(EV_EOT, 8'h00, 0, 1, 1'b0, ACK_NONE);
          return 1'b1;
        end
        return 1'b0;
      end
      RX_CAPTURE: begin
        if (c == CH_DOLLAR) begin
          // Restart: the notification flag survives.
          n = stored;
          stored = 0;
          sum_run = '0;
          r = event_of(EV_ABORT, 8'h00, 0, n, notify, ACK_NONE);
          return 1'b1;
        end
        if (c == CH_HASH) begin
          rx_phase = RX_SUM_HI;
          return 1'b0;
        end
        if (c == CH_BRACE) begin
          rx_phase = RX_ESCAPE;
          return 1'b0;
        end
        if (stored < BUFFER_BYTES) begin
          r = store_gdb_byte(c);
          return 1'b1;
        end
        n = stored;
        rx_phase = RX_IDLE;
        stored = 0;
        r = event_of(EV_ABORT, 8'h00, 0, n, notify, ACK_NONE);
        return 1'b1;
      end
      RX_ESCAPE: begin
        // An escaped byte on a full buffer is dropped silently.
        rx_phase = RX_CAPTURE;
        if (stored < BUFFER_BYTES) begin
          r = store_gdb_byte(c ^ ESC_XOR);
          return 1'b1;
        end
        return 1'b0;
      end
      RX_SUM_HI: begin
        if (!no_ack) sum_rcvd = {digit_value(c), 4'h0};
        rx_phase = RX_SUM_LO;
        return 1'b0;
      end
      RX_SUM_LO: begin
        k = EV_ACCEPT;
        a = ACK_NONE;
        if (!no_ack) begin
          sum_rcvd = sum_rcvd | {4'h0, digit_value(c)};
          if (sum_rcvd == sum_run) begin
            a = ACK_PLUS;
          end else begin
            k = EV_REJECT;
            a = ACK_MINUS;
          end
        end
        r = event_of(k, 8'h00, 0, stored, notify, a);
        rx_phase = RX_IDLE;
        stored = 0;
        notify = 1'b0;
        return 1'b1;
      end
      RX_REMOTE: begin
        n = stored;
        if (c == rx_end) begin
          rx_phase = RX_IDLE;
          stored = 0;
          r = event_of(EV_REMOTE_DONE, 8'h00, 0, n, 1'b0, ACK_NONE);
          return 1'b1;
        end
        if (c == CH_DOLLAR) begin
          begin_packet(1'b0);
          r = event_of(EV_ABORT, 8'h00, 0, n, 1'b0, ACK_NONE);
          return 1'b1;
        end
        if (stored < BUFFER_BYTES) begin
          stored++;
          r = event_of(EV_REMOTE_BYTE, c, n, 0, 1'b0, ACK_NONE);
          return 1'b1;
        end
        rx_phase = RX_IDLE;
        stored = 0;
        r = event_of(EV_ABORT, 8'h00, 0, n, 1'b0, ACK_NONE);
        return 1'b1;
      end
      default: begin
        rx_phase = RX_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t predicted;
    out_item_t due;
    if (rst) begin
      no_ack   = 1'b0;
      rx_start = RESET_REMOTE_START;
      rx_end   = RESET_REMOTE_END;
      clear_state();
      expected_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NO_ACK_MODE:  no_ack = cfg_data[0];
          CFG_REMOTE_START: rx_start = cfg_data;
          CFG_REMOTE_END:   rx_end = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (predict_event(in_data, predicted)) expected_events.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          error_count++;
          $display("%0t ns: result expected none actual %0h", $time, out_data);
        end else begin
          due = expected_events.pop_front();
          check_field("event_kind", 16'(due.event_kind), 16'(out_data.event_kind));
          check_field("byte_value", 16'(due.byte_value), 16'(out_data.byte_value));
          check_field("byte_index", 16'(due.byte_index), 16'(out_data.byte_index));
          check_field("packet_length", 16'(due.packet_length), 16'(out_data.packet_length));
          check_field("is_notification", 16'(due.is_notification),
                      16'(out_data.is_notification));
          check_field("ack_reply", 16'(due.ack_reply), 16'(out_data.ack_reply));
        end
      end
    end
    failures <= error_count;
    pending  <= expected_events.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, byte stream and result-side stalls.
// Depends on gdbd_pkg, the deframer RTL and rsp_event_checker.
module testbench;
  import gdbd_pkg::*;

  localparam int BUF_BYTES = BUFFER_BYTES_DEFAULT;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_NO_ACK_MODE;
  logic [7:0] cfg_data = '0;

  int         failures;
  int         pending;
  int         items_sent = 0;
  bit         send_rush = 1'b0;
  bit         take_rush = 1'b0;
  bit         hold_req = 1'b0;
  logic [7:0] cur_start = RESET_REMOTE_START;
  logic [7:0] cur_end = RESET_REMOTE_END;
  logic [7:0] frame_sum;

  gdb_rsp_packet_deframer #(
    .BUFFER_BYTES(BUF_BYTES)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rsp_event_checker #(
    .BUFFER_BYTES(BUF_BYTES)
  ) event_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls before items outside rushes, and one long hold.
  initial begin : receiver
    int n;
    int taken;
    taken = 0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        n = 80;
        hold_req = 1'b0;
      end else if (take_rush) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 14);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % 40 == 0) take_rush = ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send_item(input logic m, input logic [7:0] b);
    int gap;
    gap = send_rush ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {m, b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_data(input logic [7:0] b);
    send_item(1'b0, b);
  endtask

  // Drops valid and waits until every predicted result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic na, input logic [7:0] rs, input logic [7:0] re);
    cfg_we <= 1'b1;
    cfg_index <= CFG_NO_ACK_MODE;
    cfg_data <= {7'd0, na};
    @(posedge clk);
    cfg_index <= CFG_REMOTE_START;
    cfg_data <= rs;
    @(posedge clk);
    cfg_index <= CFG_REMOTE_END;
    cfg_data <= re;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_start = rs;
    cur_end = re;
  endtask

  function automatic logic [7:0] frame_weight(input logic [7:0] b);
    if (b == CH_DOLLAR || b == CH_HASH || b == CH_BRACE || b == CH_STAR)
      return CH_BRACE + (b ^ ESC_XOR);
    return b;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // Sends one data byte of a gdb packet, escaped where the framing needs it or when forced.
  task automatic send_stored(input logic [7:0] b, input bit force_esc);
    if (b == CH_DOLLAR || b == CH_HASH || b == CH_BRACE || force_esc) begin
      send_data(CH_BRACE);
      send_data(b ^ ESC_XOR);
    end else begin
      send_data(b);
    end
    frame_sum = frame_sum + frame_weight(b);
  endtask

  task automatic send_gdb_body(input int len, input bit plain_only);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (plain_only && (b == CH_DOLLAR || b == CH_HASH || b == CH_BRACE)) b = b ^ 8'h40;
      send_stored(b, !plain_only && $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic send_trailer(input logic [7:0] s, input bit good);
    logic [7:0] hi;
    logic [7:0] lo;
    if (!good && $urandom_range(0, 1) == 0) begin
      hi = 8'($urandom_range(0, 255));
      lo = 8'($urandom_range(0, 255));
    end else begin
      if (!good) s = s ^ 8'($urandom_range(1, 255));
      hi = hex_char(s[7:4]);
      lo = hex_char(s[3:0]);
    end
    send_data(CH_HASH);
    send_data(hi);
    send_data(lo);
  endtask

  task automatic send_gdb_frame(input int len, input bit good);
    send_data($urandom_range(0, 3) == 0 ? CH_PERCENT : CH_DOLLAR);
    frame_sum = '0;
    send_gdb_body(len, 1'b0);
    send_trailer(frame_sum, good);
  endtask

  task automatic send_remote_body(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == cur_end || b == CH_DOLLAR) b = b ^ 8'h80;
      send_data(b);
    end
  endtask

  task automatic random_frame();
    int r;
    r = $urandom_range(0, 99);
    send_rush = ($urandom_range(0, 4) == 0);
    if (r < 45) begin
      send_gdb_frame($urandom_range(0, 12), $urandom_range(0, 4) != 0);
    end else if (r < 65) begin
      send_data(cur_start);
      send_remote_body($urandom_range(0, 8));
      send_data(cur_end);
    end else if (r < 75) begin
      send_data(8'($urandom_range(0, 255)));
    end else if (r < 80) begin
      send_data(CH_EOT);
    end else if (r < 85) begin
      send_item(1'b1, 8'($urandom_range(0, 255)));
    end else begin
      // A packet cut short, with a fresh gdb packet landing on top of it.
      send_data($urandom_range(0, 1) ? CH_PERCENT : cur_start);
      repeat ($urandom_range(0, 4)) send_data(8'($urandom_range(0, 255)));
      send_gdb_frame($urandom_range(0, 6), 1'b1);
    end
  endtask

  initial begin : stimulus
    int base;
    int guard;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_config(1'b0, RESET_REMOTE_START, RESET_REMOTE_END);

    send_data(CH_EOT);
    send_data(8'h7e);
    // Reserved bytes in the payload, both escaped and plain.
    send_data(CH_DOLLAR);
    frame_sum = '0;
    send_stored(8'h00, 1'b0);
    send_stored(8'hff, 1'b0);
    send_stored(CH_DOLLAR, 1'b0);
    send_stored(CH_STAR, 1'b0);
    send_trailer(frame_sum, 1'b1);
    // A restart inside a notification keeps the notification flag.
    send_data(CH_PERCENT);
    send_data(8'h71);
    send_data(CH_DOLLAR);
    frame_sum = '0;
    send_stored(8'h72, 1'b0);
    send_trailer(frame_sum, 1'b1);
    // '$' inside a remote packet, then non-hex digits that read as a zero sum.
    send_data(cur_start);
    send_data(8'h79);
    send_data(CH_DOLLAR);
    send_data(CH_HASH);
    send_data(8'h67);
    send_data(8'h5a);
    send_data(cur_start);
    send_data(cur_end);
    send_data(CH_DOLLAR);
    send_data(8'h61);
    send_item(1'b1, 8'ha5);

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: set_config(1'b0, RESET_REMOTE_START, RESET_REMOTE_END);
        1: set_config(1'b1, 8'h00, 8'hff);
        2: set_config(1'b0, 8'hff, 8'h00);
        3: set_config(1'b0, CH_EOT, CH_DOLLAR);
        4: set_config(1'b1, CH_PERCENT, 8'($urandom_range(0, 255)));
        default: set_config(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      base = items_sent;
      if (p == 1) begin
        // Long hold on the result side while bytes keep coming back to back.
        hold_req = 1'b1;
        send_rush = 1'b1;
        send_gdb_frame(40, 1'b1);
      end
      if (p == 3) begin
        repeat (6) random_frame();
        settle();
      end
      while (items_sent < base + 135) random_frame();
      send_item(1'b1, 8'($urandom_range(0, 255)));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> gdb_rsp_packet_deframer.f
hw/rtl/gdbd_pkg.sv
hw/rtl/gdbd_classify.sv
hw/rtl/gdbd_queue.sv
hw/rtl/gdbd_engine.sv
hw/rtl/gdb_rsp_packet_deframer.sv
tb/rsp_event_checker.sv
tb/testbench.sv
